>>> hdl/takf_pkg.sv
package takf_pkg;

	localparam int DataW = 32;
	localparam int RegW = 31;
	localparam int CfgIdxW = 2;
	localparam int QuotW = 48;

	localparam logic [RegW-1:0] AngleNoiseRst = 31'd66;
	localparam logic [RegW-1:0] BiasNoiseRst = 31'd197;
	localparam logic [RegW-1:0] MeasNoiseRst = 31'd1966;
	localparam logic [RegW-1:0] PeriodRst = 31'd82;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ANGLE_NOISE = 2'd0,
		REG_BIAS_NOISE = 2'd1,
		REG_MEAS_NOISE = 2'd2,
		REG_PERIOD = 2'd3
	} reg_idx_t;

	// Datapath micro-operations.
	typedef enum logic [4:0] {
		OP_LOAD,       // latch the input sample
		OP_RATE,       // e = rate - bias
		OP_ANGLE_P,    // angle += dt*e
		OP_T,          // t = dt*cov_bb
		OP_INNER,      // inner = (t - ab - ba) + q_angle
		OP_AA_P,       // aa += dt*inner
		OP_AB_BA_P,    // ab -= t; ba -= t
		OP_BB_P,       // bb += q_bias*dt
		OP_YS,         // y and s
		OP_DIV0,       // start k0 division
		OP_DIV1,       // start k1 division
		OP_K0,         // capture k0
		OP_K1,         // capture k1
		OP_ANGLE_C,    // angle += k0*y
		OP_BIAS_C,     // bias += k1*y
		OP_AA_C,
		OP_AB_C,
		OP_BA_C,
		OP_BB_C,
		OP_NONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
	} dp_stat_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[DataW-1:0];
	endfunction

endpackage

>>> hdl/takf_div.sv
// Signed restoring divider, one quotient bit per cycle; quotient truncates toward zero.
module takf_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [takf_pkg::DataW-1:0] num,
	input  logic signed [takf_pkg::DataW-1:0] den,
	output logic busy,
	output logic signed [takf_pkg::DataW-1:0] quot
);
	localparam int QW = takf_pkg::QuotW;
	localparam int CntW = $clog2(QW + 1);

	logic [QW-1:0] dividend_q;
	logic [QW:0] rem_q;
	logic [takf_pkg::DataW-1:0] dvs_q;
	logic neg_q;
	logic zero_q;
	logic [CntW-1:0] cnt_q;
	logic [QW:0] shifted;
	logic [QW:0] diff;
	logic [QW-1:0] mag_num;
	logic [takf_pkg::DataW-1:0] mag_den;
	logic signed [65:0] sq;

	always_comb begin
		mag_num = num[takf_pkg::DataW-1] ? QW'(-{{16{num[31]}}, num, 16'd0}) :
			{num, 16'd0};
		mag_den = den[takf_pkg::DataW-1] ? -den : den;
		shifted = {rem_q[QW-1:0], dividend_q[QW-1]};
		diff = shifted - {{(QW + 1 - takf_pkg::DataW){1'b0}}, dvs_q};
		sq = neg_q ? -$signed({18'd0, dividend_q}) : $signed({18'd0, dividend_q});
		quot = zero_q ? '0 : takf_pkg::sat32(sq);
	end

	assign busy = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(QW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= mag_num;
			rem_q <= '0;
			dvs_q <= mag_den;
			neg_q <= num[takf_pkg::DataW-1] ^ den[takf_pkg::DataW-1];
			zero_q <= (den == '0);
		end else if (busy) begin
			if (!diff[QW]) begin
				rem_q <= diff;
				dividend_q <= {dividend_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				dividend_q <= {dividend_q[QW-2:0], 1'b0};
			end
		end
	end
endmodule

>>> hdl/takf_datapath.sv
module takf_datapath (
	input  logic clk,
	input  logic arst_n,
	input  takf_pkg::dp_cmd_t cmd,
	output takf_pkg::dp_stat_t stat,
	input  logic signed [takf_pkg::DataW-1:0] accel_angle,
	input  logic signed [takf_pkg::DataW-1:0] gyro_rate,
	input  logic [takf_pkg::RegW-1:0] q_angle,
	input  logic [takf_pkg::RegW-1:0] q_bias,
	input  logic [takf_pkg::RegW-1:0] r_meas,
	input  logic [takf_pkg::RegW-1:0] dt,
	output logic signed [takf_pkg::DataW-1:0] angle_out
);
	localparam int W = takf_pkg::DataW;

	logic signed [W-1:0] angle_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [W-1:0] acc_q, rate_q, tmp_q, t_q, y_q, s_q, k0_q, k1_q, a0_q, b0_q;
	logic signed [W-1:0] ma, mb, div_num, div_q;
	logic signed [65:0] prod, fl;
	logic div_start, div_busy;

	// One shared 32x32 multiplier, operands chosen by the current operation.
	always_comb begin
		ma = $signed({1'b0, dt});
		mb = tmp_q;
		unique case (cmd.op)
			takf_pkg::OP_T: mb = bb_q;
			takf_pkg::OP_BB_P: mb = $signed({1'b0, q_bias});
			takf_pkg::OP_ANGLE_C: begin ma = k0_q; mb = y_q; end
			takf_pkg::OP_BIAS_C: begin ma = k1_q; mb = y_q; end
			takf_pkg::OP_AA_C: begin ma = a0_q; mb = k0_q; end
			takf_pkg::OP_AB_C: begin ma = b0_q; mb = k0_q; end
			takf_pkg::OP_BA_C: begin ma = a0_q; mb = k1_q; end
			takf_pkg::OP_BB_C: begin ma = b0_q; mb = k1_q; end
			default: ;
		endcase
		prod = 66'(ma) * 66'(mb);
		fl = prod >>> 16;
		div_start = (cmd.op == takf_pkg::OP_DIV0) || (cmd.op == takf_pkg::OP_DIV1);
		div_num = (cmd.op == takf_pkg::OP_DIV1) ? ba_q : aa_q;
	end

	logic signed [W-1:0] mres;
	assign mres = takf_pkg::sat32(fl);

	takf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(s_q),
		.busy(div_busy), .quot(div_q)
	);

	assign stat.div_busy = div_busy;
	assign angle_out = angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			bias_q <= '0;
			aa_q <= '0;
			ab_q <= '0;
			ba_q <= '0;
			bb_q <= '0;
		end else begin
			unique case (cmd.op)
				takf_pkg::OP_ANGLE_P: angle_q <= takf_pkg::sat32(66'(angle_q) + 66'(mres));
				takf_pkg::OP_AA_P: aa_q <= takf_pkg::sat32(66'(aa_q) + 66'(mres));
				takf_pkg::OP_AB_BA_P: begin
					ab_q <= takf_pkg::sat32(66'(ab_q) - 66'(t_q));
					ba_q <= takf_pkg::sat32(66'(ba_q) - 66'(t_q));
				end
				takf_pkg::OP_BB_P: bb_q <= takf_pkg::sat32(66'(bb_q) + 66'(mres));
				takf_pkg::OP_ANGLE_C: angle_q <= takf_pkg::sat32(66'(angle_q) + 66'(mres));
				takf_pkg::OP_BIAS_C: bias_q <= takf_pkg::sat32(66'(bias_q) + 66'(mres));
				takf_pkg::OP_AA_C: aa_q <= takf_pkg::sat32(66'(aa_q) - 66'(mres));
				takf_pkg::OP_AB_C: ab_q <= takf_pkg::sat32(66'(ab_q) - 66'(mres));
				takf_pkg::OP_BA_C: ba_q <= takf_pkg::sat32(66'(ba_q) - 66'(mres));
				takf_pkg::OP_BB_C: bb_q <= takf_pkg::sat32(66'(bb_q) - 66'(mres));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			takf_pkg::OP_LOAD: begin acc_q <= accel_angle; rate_q <= gyro_rate; end
			takf_pkg::OP_RATE: tmp_q <= takf_pkg::sat32(66'(rate_q) - 66'(bias_q));
			takf_pkg::OP_T: t_q <= mres;
			takf_pkg::OP_INNER: tmp_q <= takf_pkg::sat32(66'(takf_pkg::sat32(
				66'(takf_pkg::sat32(66'(t_q) - 66'(ab_q))) - 66'(ba_q)))
				+ 66'($signed({1'b0, q_angle})));
			takf_pkg::OP_YS: begin
				y_q <= takf_pkg::sat32(66'(acc_q) - 66'(angle_q));
				s_q <= takf_pkg::sat32(66'(aa_q) + 66'($signed({1'b0, r_meas})));
				a0_q <= aa_q;
				b0_q <= ab_q;
			end
			takf_pkg::OP_K0: k0_q <= div_q;
			takf_pkg::OP_K1: k1_q <= div_q;
			default: ;
		endcase
	end
endmodule

>>> hdl/takf_ctrl.sv
module takf_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_fire,
	input  takf_pkg::dp_stat_t stat,
	output takf_pkg::dp_cmd_t cmd,
	output logic in_rdy,
	output logic out_vld
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SEQ  = 6'b000010,
		ST_DIV0 = 6'b000100,
		ST_DIV1 = 6'b001000,
		ST_POST = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	takf_pkg::dp_op_t op_q;
	logic div_go_q;

	always_comb begin
		cmd.op = takf_pkg::OP_NONE;
		unique case (state_q)
			ST_IDLE: if (in_fire) cmd.op = takf_pkg::OP_LOAD;
			ST_SEQ, ST_POST: cmd.op = op_q;
			ST_DIV0: if (div_go_q) cmd.op = takf_pkg::OP_DIV0;
				else if (!stat.div_busy) cmd.op = takf_pkg::OP_K0;
			ST_DIV1: if (div_go_q) cmd.op = takf_pkg::OP_DIV1;
				else if (!stat.div_busy) cmd.op = takf_pkg::OP_K1;
			ST_OUT: cmd.op = takf_pkg::OP_NONE;
			default: cmd.op = takf_pkg::OP_NONE;
		endcase
	end

	assign in_rdy = (state_q == ST_IDLE);
	assign out_vld = (state_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= takf_pkg::OP_NONE;
			div_go_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) begin
					state_q <= ST_SEQ;
					op_q <= takf_pkg::OP_RATE;
				end
				ST_SEQ: if (op_q == takf_pkg::OP_YS) begin
					state_q <= ST_DIV0;
					div_go_q <= 1'b1;
				end else begin
					op_q <= takf_pkg::dp_op_t'(op_q + 1'b1);
				end
				ST_DIV0: if (div_go_q) begin
					div_go_q <= 1'b0;
				end else if (!stat.div_busy) begin
					state_q <= ST_DIV1;
					div_go_q <= 1'b1;
				end
				ST_DIV1: if (div_go_q) begin
					div_go_q <= 1'b0;
				end else if (!stat.div_busy) begin
					state_q <= ST_POST;
					op_q <= takf_pkg::OP_ANGLE_C;
				end
				ST_POST: if (op_q == takf_pkg::OP_BB_C) begin
					state_q <= ST_OUT;
				end else begin
					op_q <= takf_pkg::dp_op_t'(op_q + 1'b1);
				end
				ST_OUT: if (out_fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/tilt_angle_kalman_filter.sv
// From input transfer to output valid: eight prediction steps, two gains (start,
// 48 quotient bits, capture) and six correction steps, all on one shared multiplier
// and one bit-serial divider. A new sample is taken only after the result
// transfer. Reset (arst_n low) clears state and covariance and loads the register
// defaults at once; no clearing pass.
module tilt_angle_kalman_filter (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [63:0] s_axis_tdata, // accel_angle[31:0], gyro_rate[63:32]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // angle_estimate[31:0]
	input  logic cfg_we,
	input  logic [takf_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [takf_pkg::RegW-1:0] cfg_data
);
	logic [takf_pkg::RegW-1:0] q_angle_q, q_bias_q, r_meas_q, dt_q;
	takf_pkg::dp_cmd_t cmd;
	takf_pkg::dp_stat_t stat;
	logic in_fire, out_fire;
	logic signed [takf_pkg::DataW-1:0] angle_out;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle_q <= takf_pkg::AngleNoiseRst;
			q_bias_q <= takf_pkg::BiasNoiseRst;
			r_meas_q <= takf_pkg::MeasNoiseRst;
			dt_q <= takf_pkg::PeriodRst;
		end else if (cfg_we) begin
			unique case (takf_pkg::reg_idx_t'(cfg_idx))
				takf_pkg::REG_ANGLE_NOISE: q_angle_q <= cfg_data;
				takf_pkg::REG_BIAS_NOISE: q_bias_q <= cfg_data;
				takf_pkg::REG_MEAS_NOISE: r_meas_q <= cfg_data;
				takf_pkg::REG_PERIOD: dt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	takf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.stat(stat), .cmd(cmd), .in_rdy(s_axis_tready), .out_vld(m_axis_tvalid)
	);

	takf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.accel_angle(s_axis_tdata[31:0]), .gyro_rate(s_axis_tdata[63:32]),
		.q_angle(q_angle_q), .q_bias(q_bias_q), .r_meas(r_meas_q), .dt(dt_q),
		.angle_out(angle_out)
	);

	assign m_axis_tdata = angle_out;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_in_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_axis_tready) else $error("ready stayed high after transfer");
endmodule

>>> sim/takf_checker.sv
module takf_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [63:0] s_axis_tdata, // accel_angle[31:0], gyro_rate[63:32]
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [31:0] m_axis_tdata, // angle_estimate[31:0]
	input  logic cfg_we,
	input  logic [takf_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [takf_pkg::RegW-1:0] cfg_data,
	output int fail_count,
	output int pending_angles,
	output int angles_seen
);
	typedef logic signed [65:0] wide_t;

	wide_t q_angle, q_bias, meas_noise, dt;
	wide_t est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
	logic signed [31:0] angle_queue[$];

	function automatic wide_t clamp(input wide_t v);
		if (v > 66'sd2147483647) begin
			return 66'sd2147483647;
		end
		if (v < -66'sd2147483648) begin
			return -66'sd2147483648;
		end
		return v;
	endfunction

	// Arithmetic shift floors, as the fixed-point product requires.
	function automatic wide_t qmul(input wide_t a, input wide_t b);
		wide_t p;
		p = a * b;
		return clamp(p >>> 16);
	endfunction

	function automatic wide_t qdiv(input wide_t num, input wide_t den);
		wide_t n;
		if (den == 0) begin
			return 0;
		end
		n = num * 66'sd65536;
		return clamp(n / den);
	endfunction

	task automatic filter_sample(input logic [63:0] sample);
		wide_t acc, rate, t, inner, y, s, k0, k1, a0, b0;
		acc = wide_t'($signed(sample[31:0]));
		rate = wide_t'($signed(sample[63:32]));
		est_angle = clamp(est_angle + qmul(dt, clamp(rate - est_bias)));
		t = qmul(dt, p_bb);
		inner = clamp(clamp(clamp(t - p_ab) - p_ba) + q_angle);
		p_aa = clamp(p_aa + qmul(dt, inner));
		p_ab = clamp(p_ab - t);
		p_ba = clamp(p_ba - t);
		p_bb = clamp(p_bb + qmul(q_bias, dt));
		y = clamp(acc - est_angle);
		s = clamp(p_aa + meas_noise);
		k0 = qdiv(p_aa, s);
		k1 = qdiv(p_ba, s);
		est_angle = clamp(est_angle + qmul(k0, y));
		est_bias = clamp(est_bias + qmul(k1, y));
		a0 = p_aa;
		b0 = p_ab;
		p_aa = clamp(p_aa - qmul(a0, k0));
		p_ab = clamp(p_ab - qmul(b0, k0));
		p_ba = clamp(p_ba - qmul(a0, k1));
		p_bb = clamp(p_bb - qmul(b0, k1));
		angle_queue.push_back(est_angle[31:0]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle = wide_t'(takf_pkg::AngleNoiseRst);
			q_bias = wide_t'(takf_pkg::BiasNoiseRst);
			meas_noise = wide_t'(takf_pkg::MeasNoiseRst);
			dt = wide_t'(takf_pkg::PeriodRst);
			est_angle = 0; est_bias = 0;
			p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
			angle_queue.delete();
			fail_count = 0;
			angles_seen = 0;
			pending_angles = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				angles_seen++;
				if (angle_queue.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected angle %h", $time, m_axis_tdata);
				end else begin
					if (angle_queue[0] !== m_axis_tdata) begin
						fail_count++;
						$display("%0t: angle_estimate expected %h actual %h", $time,
							angle_queue[0], m_axis_tdata);
					end
					void'(angle_queue.pop_front());
				end
			end
			if (cfg_we) begin
				case (takf_pkg::reg_idx_t'(cfg_idx))
					takf_pkg::REG_ANGLE_NOISE: q_angle = wide_t'(cfg_data);
					takf_pkg::REG_BIAS_NOISE: q_bias = wide_t'(cfg_data);
					takf_pkg::REG_MEAS_NOISE: meas_noise = wide_t'(cfg_data);
					takf_pkg::REG_PERIOD: dt = wide_t'(cfg_data);
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				filter_sample(s_axis_tdata);
			end
			pending_angles = angle_queue.size();
		end
	end
endmodule

>>> sim/tb_tilt_angle_kalman_filter.sv
module tb_tilt_angle_kalman_filter;
	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0; // accel_angle[31:0], gyro_rate[63:32]
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [31:0] m_axis_tdata; // angle_estimate[31:0]
	logic cfg_we = 0;
	logic [takf_pkg::CfgIdxW-1:0] cfg_idx = '0;
	logic [takf_pkg::RegW-1:0] cfg_data = '0;
	int fail_count, pending_angles, angles_seen;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int samples_sent = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	tilt_angle_kalman_filter DUT (.*);

	takf_checker u_checker (.*);

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Valid stays high after a transfer; the next call either drives a new sample
	// or drops it while idling.
	task automatic send_sample(input logic [31:0] acc, input logic [31:0] rate);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {rate, acc};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		samples_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		repeat (2) @(posedge clk);
		while (pending_angles != 0) begin
			@(posedge clk);
		end
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(input takf_pkg::reg_idx_t idx,
		input logic [takf_pkg::RegW-1:0] value);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(65536 * 4);
			3: return -$urandom_range(65536 * 4);
			default: return $urandom;
		endcase
	endfunction

	// Random IMU-like samples: mostly angles in [-90, 90] and rates in [-250, 250], else corner or random words.
	task automatic random_phase(input int count);
		logic [31:0] acc, rate;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 7) begin
				acc = $signed($urandom_range(65536 * 180)) - 65536 * 90;
				rate = $signed($urandom_range(65536 * 500)) - 65536 * 250;
			end else begin
				acc = rand_word();
				rate = rand_word();
			end
			send_sample(acc, rate);
		end
	endtask

	task automatic write_defaults();
		write_reg(takf_pkg::REG_ANGLE_NOISE, takf_pkg::AngleNoiseRst);
		write_reg(takf_pkg::REG_BIAS_NOISE, takf_pkg::BiasNoiseRst);
		write_reg(takf_pkg::REG_MEAS_NOISE, takf_pkg::MeasNoiseRst);
		write_reg(takf_pkg::REG_PERIOD, takf_pkg::PeriodRst);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Zero noise and period on the cleared covariance give a zero variance.
		write_reg(takf_pkg::REG_ANGLE_NOISE, '0);
		write_reg(takf_pkg::REG_BIAS_NOISE, '0);
		write_reg(takf_pkg::REG_MEAS_NOISE, '0);
		write_reg(takf_pkg::REG_PERIOD, '0);
		send_sample(32'h0001_0000, 32'h0002_0000);
		send_sample(32'hffff_0000, 32'h0000_0000);
		drain();
		write_defaults();
		send_sample(32'h0000_0000, 32'h0000_0000);
		send_sample(32'h7fff_ffff, 32'h7fff_ffff);
		send_sample(32'h8000_0000, 32'h8000_0000);
		send_sample(32'h7fff_ffff, 32'h8000_0000);
		send_sample(32'h8000_0000, 32'h7fff_ffff);
		send_sample(32'hffff_ffff, 32'h0001_0000);
		send_sample(32'h5555_5555, 32'haaaa_aaaa);
		send_sample(32'haaaa_aaaa, 32'h5555_5555);
		drain();
		// Large period drives the covariance into saturation and negative variance.
		write_reg(takf_pkg::REG_ANGLE_NOISE, 31'h7fff_ffff);
		write_reg(takf_pkg::REG_BIAS_NOISE, 31'h7fff_ffff);
		write_reg(takf_pkg::REG_MEAS_NOISE, 31'h7fff_ffff);
		write_reg(takf_pkg::REG_PERIOD, 31'h7fff_ffff);
		for (int i = 0; i < 8; i++) begin
			send_sample(rand_word(), rand_word());
		end
		drain();
		write_defaults();
		send_idle_pct = 27;
		recv_idle_pct = 82;
		random_phase(170);
		drain();
		write_reg(takf_pkg::REG_ANGLE_NOISE, 31'($urandom_range(2000)));
		write_reg(takf_pkg::REG_BIAS_NOISE, 31'($urandom_range(2000)));
		write_reg(takf_pkg::REG_MEAS_NOISE, 31'($urandom_range(65536)));
		write_reg(takf_pkg::REG_PERIOD, 31'($urandom_range(6554)));
		send_idle_pct = 82;
		recv_idle_pct = 27;
		random_phase(160);
		drain();
		write_reg(takf_pkg::REG_ANGLE_NOISE, 31'($urandom));
		write_reg(takf_pkg::REG_BIAS_NOISE, 31'($urandom));
		write_reg(takf_pkg::REG_MEAS_NOISE, 31'($urandom));
		write_reg(takf_pkg::REG_PERIOD, 31'($urandom));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(160);
		drain();
		$display("Sent %0d samples and checked %0d angle estimates", samples_sent,
			angles_seen);
		$display("across default, zero, saturating and random noise settings.");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
